[hw/rtl/xtea_block_cipher_top_defines.svh]
// Assertion macros shared by the cipher RTL.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef XTEA_BLOCK_CIPHER_TOP_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define XTEA_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("xtea assertion failed");

// The consequent holds in the cycle after the antecedent.
`define XTEA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xtea assertion failed");

`else

`define XTEA_ASSERT_ALWAYS(label, clk, rstn, cond)
`define XTEA_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/xtea_pkg.sv]
package xtea_pkg;

    // Data widths.
    localparam int WORD_W     = 32;
    localparam int CFG_ADDR_W = 3;

    // Defaults for the top-level parameters.
    localparam int NUM_CYCLES_DEFAULT  = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Mixing function shifts and key selector position.
    localparam int MIX_SHL       = 4;
    localparam int MIX_SHR       = 5;
    localparam int KEY_SEL_SHIFT = 11;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_KEY0  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY1  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY2  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY3  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DELTA = 3'd4;

    // Reset values.
    localparam logic [WORD_W-1:0] KEY_RESET   = 32'h0000_0000;
    localparam logic [WORD_W-1:0] DELTA_RESET = 32'h9E37_79B9;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [3:0][WORD_W-1:0] key_t;

    // One input item as it waits in the queue.
    typedef struct packed {
        logic  cmd;
        word_t v0;
        word_t v1;
    } item_t;

    // One item in flight through the round pipeline.
    typedef struct packed {
        logic  cmd;
        word_t sum;
        word_t v0;
        word_t v1;
    } stage_t;

    // One Feistel half-round. Encryption runs (v0 update, sum += delta) then
    // (v1 update); decryption runs (v1 update, sum -= delta) then (v0 update).
    // The half that updates v0 keys on sum[1:0], the other on sum[12:11].
    function automatic stage_t half_round(stage_t s, logic odd, key_t k, word_t delta);
        logic       enc;
        logic       upd_v0;
        word_t      src;
        word_t      mixed;
        word_t      keyed;
        logic [1:0] idx;
        stage_t     r;
        enc    = (s.cmd == CMD_ENCRYPT);
        upd_v0 = enc ^ odd;
        r      = s;
        src    = upd_v0 ? s.v1 : s.v0;
        idx    = upd_v0 ? s.sum[1:0] : s.sum[KEY_SEL_SHIFT +: 2];
        mixed  = ((src << MIX_SHL) ^ (src >> MIX_SHR)) + src;
        keyed  = mixed ^ (s.sum + k[idx]);
        if (upd_v0) begin
            r.v0 = enc ? (s.v0 + keyed) : (s.v0 - keyed);
        end else begin
            r.v1 = enc ? (s.v1 + keyed) : (s.v1 - keyed);
        end
        if (!odd) begin
            r.sum = enc ? (s.sum + delta) : (s.sum - delta);
        end
        return r;
    endfunction

endpackage

[hw/rtl/xtea_front.sv]
`include "xtea_block_cipher_top_defines.svh"

module xtea_front
    import xtea_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  item_t  in_item,
    input  word_t  start_sum,
    output logic   head_valid,
    output stage_t head,
    input  logic   pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    item_t            head_item;

    // Accept an item whenever the queue has room.
    assign in_ready   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Classify the head item: decryption starts the round sum at delta times
    // the cycle count, encryption at zero.
    assign head_item = queue_reg[rd_ptr_reg];
    always_comb begin
        head.cmd = head_item.cmd;
        head.sum = (head_item.cmd == CMD_DECRYPT) ? start_sum : '0;
        head.v0  = head_item.v0;
        head.v1  = head_item.v1;
    end

    `XTEA_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH))
    `XTEA_ASSERT_NEXT(a_pop_drains, aclk, aresetn, pop && !push, count_reg == CNT_W'($past(count_reg) - 1'b1))
    `XTEA_ASSERT_NEXT(a_push_fills, aclk, aresetn, push && !pop, count_reg == CNT_W'($past(count_reg) + 1'b1))

endmodule

[hw/rtl/xtea_back.sv]
`include "xtea_block_cipher_top_defines.svh"

module xtea_back
    import xtea_pkg::*;
#(
    parameter int NUM_CYCLES = NUM_CYCLES_DEFAULT
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   head_valid,
    input  stage_t head,
    output logic   pop,
    input  key_t   key,
    input  word_t  delta,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_item
);

    localparam int NUM_STAGES = 2 * NUM_CYCLES;

    stage_t                stage_reg [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic                  advance;

    // The whole pipeline moves unless the last stage holds an untaken result.
    assign advance   = !valid_reg[NUM_STAGES-1] || out_ready;
    assign pop       = advance && head_valid;
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_item  = stage_reg[NUM_STAGES-1];

    // Valid bits shift along with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], head_valid};
        end
    end

    // One half-round per stage; even stages run the first half of a cycle.
    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
        localparam logic ODD = ((i % 2) == 1);
        if (i == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (advance) begin
                    stage_reg[i] <= half_round(head, ODD, key, delta);
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (advance) begin
                    stage_reg[i] <= half_round(stage_reg[i-1], ODD, key, delta);
                end
            end
        end
    end

    `XTEA_ASSERT_NEXT(a_stall_holds, aclk, aresetn, !advance, $stable(valid_reg))
    `XTEA_ASSERT_NEXT(a_head_enters, aclk, aresetn, pop, valid_reg[0])

endmodule

[hw/rtl/xtea_block_cipher_top.sv]
// XTEA 64-bit block cipher in ECB mode. Each input item carries one block as
// two 32-bit words (block_low in tdata[31:0], block_high in tdata[63:32]) and
// a command bit in tuser (0 encrypts, 1 decrypts); each result item carries the
// two transformed words in the same layout. The 128-bit key and the round
// constant are written through the configuration port (index 0..3: key words,
// index 4: delta, reset 0x9E3779B9); the user must write them only while no
// item is in flight, which the block itself does not enforce. The cipher is
// fully unrolled into 2*NUM_CYCLES pipeline stages, one Feistel half-round
// each, so one block is taken and one result given every cycle unless the
// output stalls. Each item passes through the QUEUE_DEPTH-entry input queue
// and one register per half-round stage. The queue keeps accepting items until
// full while a result waits; the pipeline holds still while the output stalls.
`include "xtea_block_cipher_top_defines.svh"

module xtea_block_cipher_top
    import xtea_pkg::*;
#(
    parameter int NUM_CYCLES  = NUM_CYCLES_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]     cfg_wr_data,
    // Input item channel.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // block_low[31:0], block_high[63:32]
    input  logic                  s_axis_tuser,  // command[0]
    // Result item channel.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata   // out_low[31:0], out_high[63:32]
);

    key_t   key_reg;
    word_t  delta_reg;
    word_t  start_sum_reg;
    item_t  in_item;
    stage_t head;
    logic   head_valid;
    logic   pop;
    stage_t out_item;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= {4{KEY_RESET}};
            delta_reg <= DELTA_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KEY0:  key_reg[0] <= cfg_wr_data;
                REG_KEY1:  key_reg[1] <= cfg_wr_data;
                REG_KEY2:  key_reg[2] <= cfg_wr_data;
                REG_KEY3:  key_reg[3] <= cfg_wr_data;
                REG_DELTA: delta_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Starting sum for decryption, recomputed every cycle from delta.
    always_ff @(posedge aclk) begin
        start_sum_reg <= WORD_W'(delta_reg * NUM_CYCLES);
    end

    // Unpack the input item.
    always_comb begin
        in_item.cmd = s_axis_tuser;
        in_item.v0  = s_axis_tdata[31:0];
        in_item.v1  = s_axis_tdata[63:32];
    end

    xtea_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .start_sum  (start_sum_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    xtea_back #(
        .NUM_CYCLES (NUM_CYCLES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .key        (key_reg),
        .delta      (delta_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    // Pack the result item.
    assign m_axis_tdata = {out_item.v1, out_item.v0};

    `XTEA_ASSERT_NEXT(a_start_sum, aclk, aresetn, 1'b1, start_sum_reg == WORD_W'($past(delta_reg) * NUM_CYCLES))
    `XTEA_ASSERT_NEXT(a_delta_kept, aclk, aresetn, !cfg_wr_en, $stable(delta_reg))

endmodule
